### src/pfc_pkg.sv
// Shared constants for the Playfair digraph cipher: letter codes, keyword
// sizing and configuration register indexes.
// No dependencies.
package pfc_pkg;

    localparam int MAX_KEYWORD = 9;
    localparam int LETTER_W    = 5;
    localparam int KW_LEN_W    = 4;
    localparam int KW_W        = LETTER_W * MAX_KEYWORD;
    localparam int ALPHABET    = 26;
    localparam int SQUARE_SIZE = 25;
    localparam int BUILD_STEPS = MAX_KEYWORD + ALPHABET;
    localparam int STEP_W      = $clog2(BUILD_STEPS);
    localparam int SLOT_W      = (MAX_KEYWORD > 1) ? $clog2(MAX_KEYWORD) : 1;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LETTER_W-1:0] LETTER_I = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J = 5'd9;
    localparam logic [LETTER_W-1:0] LETTER_X = 5'd23;
    localparam logic [LETTER_W-1:0] LETTER_Z = 5'd25;

    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LETTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYWORD_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION       = 2'd2;

    // Grid coordinate, 0 to 4.
    typedef logic [2:0] coord_t;

    // Cell index of a grid position.
    function automatic logic [LETTER_W-1:0] cell_index(input coord_t row, input coord_t col);
        logic [LETTER_W-1:0] r5;
        r5 = {row[2:0], 2'b00};
        return r5 + {2'b00, row} + {2'b00, col};
    endfunction

    // One step around a row or column, forward or backward.
    function automatic coord_t wrap_step(input coord_t v, input logic backward);
        coord_t r;
        if (backward)
        begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end
        else
        begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

endpackage

### src/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: key square builder, letter pairing
// and the three-stage lookup pipeline.
// Depends on pfc_pkg.
//
// Usage:
// Letters enter on the input channel (in_valid/in_ready, letter, final_letter),
// one word per cycle while in_ready is high. Transformed pairs leave on the
// output channel (out_valid/out_ready, first_out, second_out, message_end).
// The first letter of a pair is held internally; the second one releases the
// pair. A pair appears on the output after the letter that completes it is
// accepted: the pairing register loads at that edge, then the coordinate
// lookup and the square lookup into the output register follow.
// Throughput is one word per cycle in both directions while nothing stalls. An
// equal pair on the final letter while encrypting yields two output words, so
// the input is held off until the second word enters the pipeline.
// Configuration writes (cfg_write, cfg_index, cfg_data) to a defined index
// rebuild the key square. The rebuild walks the keyword slots and then the
// alphabet, one candidate a cycle, with in_ready low. The same pass runs
// after reset, which clears configuration and the pending letter. When the
// receiver stalls, the whole pipeline holds and in_ready drops, so nothing is
// lost; the pending letter survives a configuration write.
module playfair_digraph_cipher (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [pfc_pkg::LETTER_W-1:0]     letter,
    input  logic                             final_letter,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [pfc_pkg::LETTER_W-1:0]     first_out,
    output logic [pfc_pkg::LETTER_W-1:0]     second_out,
    output logic                             message_end,
    input  logic                             cfg_write,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pfc_pkg::KW_W-1:0]         cfg_data
);

    localparam int LW = pfc_pkg::LETTER_W;

    // Configuration
    logic [pfc_pkg::KW_W-1:0]     kw_letters_reg;
    logic [pfc_pkg::KW_LEN_W-1:0] kw_length_reg;
    logic                         direction_reg;
    logic                         cfg_hit;

    // Square builder
    logic                            building_reg;
    logic [pfc_pkg::STEP_W-1:0]      step_reg;
    logic [pfc_pkg::ALPHABET-1:0]    used_reg;
    logic [LW-1:0]                   fill_cnt_reg;
    pfc_pkg::coord_t                 fill_row_reg;
    pfc_pkg::coord_t                 fill_col_reg;
    logic [pfc_pkg::KW_LEN_W-1:0]    len_sat;
    logic                            in_kw;
    logic [pfc_pkg::SLOT_W-1:0]      slot;
    logic [pfc_pkg::STEP_W-1:0]      alpha_step;
    logic [LW-1:0]                   cand_raw;
    logic [LW-1:0]                   cand;
    logic                            cand_ok;
    logic                            fill_we;

    // Memories
    logic [LW-1:0] square_mem [pfc_pkg::SQUARE_SIZE];
    logic [5:0]    coord_mem  [pfc_pkg::ALPHABET];

    // Pairing state
    logic          pend_valid_reg;
    logic [LW-1:0] pend_letter_reg;
    logic          hold_valid_reg;
    logic [LW-1:0] hold_letter_reg;
    logic [LW-1:0] in_letter;
    logic          accept;
    logic          adv;

    // Stage 0: pair request
    logic          s0_valid_reg;
    logic [LW-1:0] s0_a_reg;
    logic [LW-1:0] s0_b_reg;
    logic          s0_last_reg;
    logic          req_valid;
    logic [LW-1:0] req_a;
    logic [LW-1:0] req_b;
    logic          req_last;
    logic          hold_set;

    // Stage 1: coordinates
    logic          s1_valid_reg;
    logic [5:0]    s1_pa_reg;
    logic [5:0]    s1_pb_reg;
    logic          s1_last_reg;

    // Stage 2: output register
    logic          out_valid_reg;
    logic [LW-1:0] out_first_reg;
    logic [LW-1:0] out_second_reg;
    logic          out_end_reg;

    logic [LW-1:0] idx1;
    logic [LW-1:0] idx2;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv && !hold_valid_reg && !building_reg;
    assign accept   = in_valid && in_ready;

    // ---------------- configuration ----------------
    always_comb
    begin
        unique case (cfg_index)
            pfc_pkg::CFG_KEYWORD_LETTERS,
            pfc_pkg::CFG_KEYWORD_LENGTH,
            pfc_pkg::CFG_DIRECTION:       cfg_hit = cfg_write;
            default:                      cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_letters_reg <= '0;
            kw_length_reg  <= '0;
            direction_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pfc_pkg::CFG_KEYWORD_LETTERS: kw_letters_reg <= cfg_data;
                pfc_pkg::CFG_KEYWORD_LENGTH:  kw_length_reg  <= cfg_data[pfc_pkg::KW_LEN_W-1:0];
                pfc_pkg::CFG_DIRECTION:       direction_reg  <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // ---------------- square builder ----------------
    always_comb
    begin
        len_sat    = (kw_length_reg > pfc_pkg::KW_LEN_W'(pfc_pkg::MAX_KEYWORD))
                     ? pfc_pkg::KW_LEN_W'(pfc_pkg::MAX_KEYWORD) : kw_length_reg;
        in_kw      = step_reg < pfc_pkg::STEP_W'(pfc_pkg::MAX_KEYWORD);
        slot       = step_reg[pfc_pkg::SLOT_W-1:0];
        alpha_step = step_reg - pfc_pkg::STEP_W'(pfc_pkg::MAX_KEYWORD);
        if (in_kw)
        begin
            cand_raw = kw_letters_reg[LW*int'(slot) +: LW];
            cand_ok  = (pfc_pkg::KW_LEN_W'(slot) < len_sat) && (cand_raw <= pfc_pkg::LETTER_Z);
        end
        else
        begin
            cand_raw = alpha_step[LW-1:0];
            cand_ok  = cand_raw != pfc_pkg::LETTER_J;
        end
        cand    = (cand_raw == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : cand_raw;
        // A keyword code above z never reaches the used-mask lookup.
        fill_we = building_reg && cand_ok
                  && (fill_cnt_reg < LW'(pfc_pkg::SQUARE_SIZE)) && !used_reg[cand];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            building_reg <= 1'b1;
            step_reg     <= '0;
            used_reg     <= '0;
            fill_cnt_reg <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
        end
        else if (cfg_hit)
        begin
            building_reg <= 1'b1;
            step_reg     <= '0;
            used_reg     <= '0;
            fill_cnt_reg <= '0;
            fill_row_reg <= '0;
            fill_col_reg <= '0;
        end
        else if (building_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == pfc_pkg::STEP_W'(pfc_pkg::BUILD_STEPS - 1))
            begin
                building_reg <= 1'b0;
            end
            if (fill_we)
            begin
                used_reg[cand] <= 1'b1;
                fill_cnt_reg   <= fill_cnt_reg + 1'b1;
                if (fill_col_reg == 3'd4)
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + 1'b1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            square_mem[pfc_pkg::cell_index(fill_row_reg, fill_col_reg)] <= cand;
            coord_mem[cand] <= {fill_row_reg, fill_col_reg};
        end
    end

    // ---------------- pairing ----------------
    always_comb
    begin
        in_letter = (letter > pfc_pkg::LETTER_Z) ? pfc_pkg::LETTER_Z : letter;
        if (in_letter == pfc_pkg::LETTER_J)
        begin
            in_letter = pfc_pkg::LETTER_I;
        end
        req_valid = 1'b0;
        req_a     = pend_letter_reg;
        req_b     = in_letter;
        req_last  = final_letter;
        hold_set  = 1'b0;
        if (!pend_valid_reg)
        begin
            if (final_letter)
            begin
                req_valid = 1'b1;
                req_a     = in_letter;
                req_b     = pfc_pkg::LETTER_X;
            end
        end
        else if (!direction_reg && (in_letter == pend_letter_reg))
        begin
            // Equal pair while encrypting: x goes in after the first letter.
            req_valid = 1'b1;
            req_b     = pfc_pkg::LETTER_X;
            req_last  = 1'b0;
            hold_set  = final_letter;
        end
        else
        begin
            req_valid = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            hold_valid_reg <= 1'b0;
            s0_valid_reg   <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s0_valid_reg;
            out_valid_reg <= s1_valid_reg;
            if (hold_valid_reg)
            begin
                s0_valid_reg   <= 1'b1;
                hold_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                s0_valid_reg   <= req_valid;
                hold_valid_reg <= hold_set;
                // A first word stays pending unless it is final. A word that completes a
                // pair clears it, but the second of a doubled pair (encrypting) stays unless final.
                pend_valid_reg <= !pend_valid_reg ? !final_letter
                                  : (hold_set ? 1'b0
                                     : !req_last && (req_b == pfc_pkg::LETTER_X)
                                       && !direction_reg && (in_letter == pend_letter_reg));
            end
            else
            begin
                s0_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (!pend_valid_reg || (!direction_reg && (in_letter == pend_letter_reg))))
        begin
            pend_letter_reg <= in_letter;
        end
        if (accept && hold_set)
        begin
            hold_letter_reg <= in_letter;
        end
        if (adv)
        begin
            if (hold_valid_reg)
            begin
                s0_a_reg    <= hold_letter_reg;
                s0_b_reg    <= pfc_pkg::LETTER_X;
                s0_last_reg <= 1'b1;
            end
            else
            begin
                s0_a_reg    <= req_a;
                s0_b_reg    <= req_b;
                s0_last_reg <= req_last;
            end
            s1_pa_reg      <= coord_mem[s0_a_reg];
            s1_pb_reg      <= coord_mem[s0_b_reg];
            s1_last_reg    <= s0_last_reg;
            out_first_reg  <= square_mem[idx1];
            out_second_reg <= square_mem[idx2];
            out_end_reg    <= s1_last_reg;
        end
    end

    // ---------------- digraph rules ----------------
    always_comb
    begin
        pfc_pkg::coord_t ra;
        pfc_pkg::coord_t ca;
        pfc_pkg::coord_t rb;
        pfc_pkg::coord_t cb;
        ra = s1_pa_reg[5:3];
        ca = s1_pa_reg[2:0];
        rb = s1_pb_reg[5:3];
        cb = s1_pb_reg[2:0];
        if (ra == rb)
        begin
            idx1 = pfc_pkg::cell_index(ra, pfc_pkg::wrap_step(ca, direction_reg));
            idx2 = pfc_pkg::cell_index(rb, pfc_pkg::wrap_step(cb, direction_reg));
        end
        else if (ca == cb)
        begin
            idx1 = pfc_pkg::cell_index(pfc_pkg::wrap_step(ra, direction_reg), ca);
            idx2 = pfc_pkg::cell_index(pfc_pkg::wrap_step(rb, direction_reg), cb);
        end
        else
        begin
            idx1 = pfc_pkg::cell_index(ra, cb);
            idx2 = pfc_pkg::cell_index(rb, ca);
        end
    end

    assign out_valid   = out_valid_reg;
    assign first_out   = out_first_reg;
    assign second_out  = out_second_reg;
    assign message_end = out_end_reg;

    // ---------------- assertions ----------------
    a_no_accept_while_building : assert property (@(posedge clk) disable iff (!rst_n)
        building_reg |-> !in_ready)
        else $error("input accepted while the key square is being built");

    a_hold_needs_request : assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> s0_valid_reg)
        else $error("held second pair without a first pair in flight");

    a_final_clears_pending : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && final_letter) |=> !pend_valid_reg)
        else $error("pending letter left after the final letter");

    a_build_step_range : assert property (@(posedge clk) disable iff (!rst_n)
        building_reg |-> (step_reg < pfc_pkg::STEP_W'(pfc_pkg::BUILD_STEPS)))
        else $error("square build step out of range");

endmodule
